>>> rtl/prm_pkg.sv
package prm_pkg;

  localparam int unsigned DefaultDepth = 64;

  localparam logic [15:0] StaleTimeoutReset = 16'd5000;
  localparam logic [15:0] OutlierTolReset   = 16'd500;

  typedef enum logic [1:0] {
    KindRecord = 2'd0,
    KindMatch  = 2'd1,
    KindPrune  = 2'd2,
    KindClear  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    CellHold   = 2'd0,
    CellShift  = 2'd1,
    CellRotate = 2'd2,
    CellAppend = 2'd3
  } cell_op_e;

  typedef struct packed {
    logic [31:0] action;
    logic [31:0] sequence_num;
    logic [31:0] stamp;
    logic        cast_flag;
    logic [15:0] cast_ms;
  } entry_t;

  typedef struct packed {
    cell_op_e op;
    entry_t   fresh;
  } cell_ctrl_t;

endpackage

>>> rtl/pending_request_matcher_unit.sv
// Channel   Direction  Handshake             Payload
// command   in         start & !busy         kind, action, sequence, time, cast, rtt
// result    out        done strobe, 1 cycle  matched, hit fields, pruned/pending counts
// config    in         APB write access      stale timeout, outlier tolerance
//
// An item first pops stale entries off the head, then runs a sequence scan and/or an action
// scan as its kind asks, and for a record appends the new entry; when the table is full,
// the oldest entry is shifted out before the append.
// Every scan walks the row of cells one entry per cycle through the head cell.
// Reset empties the table at once; entries keep no reset.
// The result is shown for one cycle, cannot be held off, and a new beat can be taken in the cycle after it.
module pending_request_matcher_unit #(
  parameter int unsigned DEPTH = prm_pkg::DefaultDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  kind_i,
  input  logic [31:0] action_id_i,
  input  logic [31:0] sequence_req_i,
  input  logic [31:0] timestamp_i,
  input  logic        is_cast_i,
  input  logic [15:0] cast_ms_i,
  input  logic [15:0] expected_rtt_ms_i,
  output logic        done_o,
  output logic        matched_o,
  output logic [31:0] hit_action_id_o,
  output logic [31:0] hit_sequence_o,
  output logic [31:0] hit_timestamp_o,
  output logic        hit_is_cast_o,
  output logic [15:0] hit_cast_ms_o,
  output logic [6:0]  pruned_count_o,
  output logic [6:0]  pending_count_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned CW = $clog2(DEPTH + 1);

  typedef enum logic [5:0] {
    StIdle   = 6'b000001,
    StPrune  = 6'b000010,
    StSeq    = 6'b000100,
    StAct    = 6'b001000,
    StAppend = 6'b010000,
    StDone   = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic [15:0] timeout_q, tol_q;

  logic [1:0]  kind_q;
  logic [31:0] act_q, seq_q, now_q;
  logic        cast_q;
  logic [15:0] cms_q, rtt_q;

  logic [CW-1:0] count_q, count_d, rem_q, rem_d, pruned_q, pruned_d;
  logic          have_q, have_d, final_q, final_d;
  prm_pkg::entry_t cand_q, cand_d;

  prm_pkg::cell_ctrl_t ctrl;
  prm_pkg::entry_t     cells [DEPTH];
  prm_pkg::entry_t     head;

  logic              accept;
  logic              stale, late;
  logic [16:0]       thr_a, thr_b, thr;
  logic [33:0]       late_sum;
  logic [15:0]       head_ct;

  assign accept = start && (state_q == StIdle);
  assign busy   = (state_q != StIdle);
  assign head   = cells[0];

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    prm_pkg::entry_t right;
    if (g == DEPTH - 1) begin : g_last
      assign right = cells[g];
    end else begin : g_mid
      assign right = cells[g+1];
    end
    prm_cell #(
      .DEPTH (DEPTH),
      .IDX   (g),
      .CW    (CW)
    ) u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .count_i (count_q),
      .head_i  (head),
      .right_i (right),
      .entry_o (cells[g])
    );
  end

  assign stale = ({1'b0, head.stamp} + {17'd0, timeout_q}) < {1'b0, now_q};

  assign thr_a    = {rtt_q, 1'b0};
  assign thr_b    = {1'b0, rtt_q} + {1'b0, tol_q};
  assign thr      = (thr_a > thr_b) ? thr_a : thr_b;
  assign head_ct  = head.cast_flag ? head.cast_ms : 16'd0;
  assign late_sum = {2'b0, head.stamp} + {18'd0, head_ct} + {17'd0, thr};
  assign late     = {2'b0, now_q} > late_sum;

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    rem_d    = rem_q;
    pruned_d = pruned_q;
    have_d   = have_q;
    final_d  = final_q;
    cand_d   = cand_q;
    ctrl.op  = prm_pkg::CellHold;
    ctrl.fresh.action       = act_q;
    ctrl.fresh.sequence_num = seq_q;
    ctrl.fresh.stamp        = now_q;
    ctrl.fresh.cast_flag    = cast_q;
    ctrl.fresh.cast_ms      = cms_q;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          state_d  = StPrune;
          pruned_d = '0;
          have_d   = 1'b0;
          final_d  = 1'b0;
        end
      end
      StPrune: begin
        if (count_q != '0 && stale) begin
          ctrl.op  = prm_pkg::CellShift;
          count_d  = count_q - CW'(1);
          pruned_d = pruned_q + CW'(1);
        end else begin
          rem_d = count_q;
          unique case (prm_pkg::kind_e'(kind_q))
            prm_pkg::KindRecord: state_d = (seq_q != '0) ? StSeq : StAppend;
            prm_pkg::KindMatch: begin
              if (seq_q != '0) begin
                state_d = StSeq;
              end else if (act_q != '0) begin
                state_d = StAct;
              end else begin
                state_d = StDone;
              end
            end
            prm_pkg::KindPrune: state_d = StDone;
            prm_pkg::KindClear: begin
              count_d = '0;
              state_d = StDone;
            end
          endcase
        end
      end
      StSeq: begin
        if (rem_q == '0) begin
          rem_d = count_q;
          if (prm_pkg::kind_e'(kind_q) == prm_pkg::KindRecord) begin
            state_d = StAppend;
          end else if (!have_q && act_q != '0) begin
            state_d = StAct;
          end else begin
            state_d = StDone;
          end
        end else begin
          rem_d = rem_q - CW'(1);
          if (!have_q && head.sequence_num == seq_q) begin
            ctrl.op = prm_pkg::CellShift;
            count_d = count_q - CW'(1);
            have_d  = 1'b1;
            cand_d  = head;
          end else begin
            ctrl.op = prm_pkg::CellRotate;
          end
        end
      end
      StAct: begin
        if (rem_q == '0) begin
          state_d = StDone;
        end else begin
          rem_d = rem_q - CW'(1);
          if (!final_q && head.action == act_q) begin
            ctrl.op = prm_pkg::CellShift;
            count_d = count_q - CW'(1);
            have_d  = 1'b1;
            cand_d  = head;
            final_d = !((rtt_q != '0) && late);
          end else begin
            ctrl.op = prm_pkg::CellRotate;
          end
        end
      end
      StAppend: begin
        if (count_q == CW'(DEPTH)) begin
          ctrl.op = prm_pkg::CellShift;
          count_d = count_q - CW'(1);
        end else begin
          ctrl.op = prm_pkg::CellAppend;
          count_d = count_q + CW'(1);
          state_d = StDone;
        end
      end
      StDone: state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      count_q  <= '0;
      rem_q    <= '0;
      pruned_q <= '0;
      have_q   <= 1'b0;
      final_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      rem_q    <= rem_d;
      pruned_q <= pruned_d;
      have_q   <= have_d;
      final_q  <= final_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cand_q <= cand_d;
    if (accept) begin
      kind_q <= kind_i;
      act_q  <= action_id_i;
      seq_q  <= sequence_req_i;
      now_q  <= timestamp_i;
      cast_q <= is_cast_i;
      cms_q  <= cast_ms_i;
      rtt_q  <= expected_rtt_ms_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= prm_pkg::StaleTimeoutReset;
      tol_q     <= prm_pkg::OutlierTolReset;
    end else if (psel && penable && pwrite) begin
      if (paddr[2]) begin
        tol_q <= pwdata[15:0];
      end else begin
        timeout_q <= pwdata[15:0];
      end
    end
  end

  assign pready = 1'b1;
  assign prdata = paddr[2] ? {16'd0, tol_q} : {16'd0, timeout_q};

  logic          hit;
  logic [CW+6:0] pruned_ext, count_ext;

  assign hit        = have_q && (prm_pkg::kind_e'(kind_q) == prm_pkg::KindMatch);
  assign pruned_ext = {7'd0, pruned_q};
  assign count_ext  = {7'd0, count_q};

  assign done_o          = (state_q == StDone);
  assign matched_o       = done_o && hit;
  assign hit_action_id_o = matched_o ? cand_q.action : 32'd0;
  assign hit_sequence_o  = matched_o ? cand_q.sequence_num : 32'd0;
  assign hit_timestamp_o = matched_o ? cand_q.stamp : 32'd0;
  assign hit_is_cast_o   = matched_o ? cand_q.cast_flag : 1'b0;
  assign hit_cast_ms_o   = matched_o ? cand_q.cast_ms : 16'd0;
  assign pruned_count_o  = pruned_ext[6:0];
  assign pending_count_o = count_ext[6:0];

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("Table occupancy exceeds its depth.");

  a_done_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy))
    else $error("Result strobe without an item in progress.");

  a_match_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    matched_o |-> (prm_pkg::kind_e'(kind_q) == prm_pkg::KindMatch))
    else $error("Hit reported for an item that is not a match.");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("Accepted beat did not start work.");
`endif

endmodule

>>> rtl/prm_cell.sv
module prm_cell #(
  parameter int unsigned DEPTH = prm_pkg::DefaultDepth,
  parameter int unsigned IDX   = 0,
  parameter int unsigned CW    = $clog2(DEPTH + 1)
) (
  input  logic                clk_i,
  input  prm_pkg::cell_ctrl_t ctrl_i,
  input  logic [CW-1:0]       count_i,
  input  prm_pkg::entry_t     head_i,
  input  prm_pkg::entry_t     right_i,
  output prm_pkg::entry_t     entry_o
);

  prm_pkg::entry_t entry_q, entry_d;

  always_comb begin
    entry_d = entry_q;
    unique case (ctrl_i.op)
      prm_pkg::CellHold: entry_d = entry_q;
      prm_pkg::CellShift: entry_d = right_i;
      prm_pkg::CellRotate: begin
        entry_d = (count_i == CW'(IDX + 1)) ? head_i : right_i;
      end
      prm_pkg::CellAppend: begin
        if (count_i == CW'(IDX)) begin
          entry_d = ctrl_i.fresh;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule
